### rtl/lcm_gcd_unit_macros.svh
// assertion macros shared by the lcm/gcd checker
`ifndef LCM_GCD_UNIT_MACROS_SVH
`define LCM_GCD_UNIT_MACROS_SVH

// clocked assertion that is switched off while reset is held
`define LG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked assertion that also runs during reset
`define LG_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### rtl/lcmgcd_pkg.sv
// ----------------------------------------------------------------------------
// lcmgcd_pkg
// Types and constants shared by the lcm/gcd controller, datapath and checker.
// ----------------------------------------------------------------------------
package lcmgcd_pkg;

    // field widths of the request and result
    localparam int OPND_W = 16;
    localparam int LCM_W  = 32;
    localparam int GCD_W  = 16;

    // request payload
    typedef struct packed {
        logic [OPND_W-1:0] operand_a;
        logic [OPND_W-1:0] operand_b;
    } t_lg_in;

    // result payload
    typedef struct packed {
        logic [LCM_W-1:0] lcm_value;
        logic [GCD_W-1:0] gcd_value;
        logic             invalid;
    } t_lg_out;

    // commands from controller to datapath
    typedef struct packed {
        logic load;      // capture operands, clear accumulators
        logic twos;      // strip one common factor of two
        logic gcd_step;  // one binary gcd reduction
        logic gcd_done;  // latch the divisor
        logic div_step;  // one restoring division step
        logic mul_step;  // one shift-add multiply step
        logic finish;    // write the result register
    } t_lg_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic zero_op;   // an operand is zero
        logic both_even; // both working values are even
        logic equal;     // working values match, gcd found
        logic cnt_last;  // last division or multiply step
    } t_lg_sts;

endpackage

### rtl/lcm_gcd_unit.sv
// A request runs through common-twos removal, binary gcd reductions, division of a by
// the gcd and the shift-add multiply before the finish writes the result register.
// A zero operand skips the gcd, divide and multiply steps and goes straight to the finish.
// One request at a time: the next is taken the cycle after the result is registered.
// Divider and multiplier take one operand bit per cycle; a stalled result holds the finish.
// Reset (synchronous, active low) returns the sequencer to idle and drops output valid.
// ----------------------------------------------------------------------------
// lcm_gcd_unit
// Least common multiple and greatest common divisor of two unsigned operands,
// with an invalid flag when either operand is zero.
// ----------------------------------------------------------------------------
module lcm_gcd_unit #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  lcmgcd_pkg::t_lg_in i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output lcmgcd_pkg::t_lg_out o_out_data
);
    import lcmgcd_pkg::*;

    t_lg_cmd w_cmd;
    t_lg_sts w_sts;

    // sequencer
    lcmgcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    // arithmetic
    lcmgcd_dp #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_in_data  (i_in_data),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_out_data (o_out_data)
    );

endmodule

### rtl/lcmgcd_ctrl.sv
// ----------------------------------------------------------------------------
// lcmgcd_ctrl
// Sequencer for the lcm/gcd unit: steps the datapath through common-twos
// removal, binary gcd, division of a by the gcd and the final multiply.
// ----------------------------------------------------------------------------
module lcmgcd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output lcmgcd_pkg::t_lg_cmd o_cmd,
    input  lcmgcd_pkg::t_lg_sts i_sts
);
    import lcmgcd_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TWOS = 3'd1;
    localparam logic [2:0] S_GCD  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    t_lg_cmd    w_cmd;

    // next state and command decode
    always_comb begin
        n_state     = r_state;
        w_cmd       = '0;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    n_state    = S_TWOS;
                end
            end
            S_TWOS: begin
                priority if (i_sts.zero_op) begin
                    n_state = S_FIN;
                end else if (i_sts.both_even) begin
                    w_cmd.twos = 1'b1;
                end else begin
                    n_state = S_GCD;
                end
            end
            S_GCD: begin
                if (i_sts.equal) begin
                    w_cmd.gcd_done = 1'b1;
                    n_state        = S_DIV;
                end else begin
                    w_cmd.gcd_step = 1'b1;
                end
            end
            S_DIV: begin
                w_cmd.div_step = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                w_cmd.mul_step = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // output slot free or draining this cycle
                if (!r_out_valid || !i_out_stall) begin
                    w_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

endmodule

### rtl/lcmgcd_dp.sv
// ----------------------------------------------------------------------------
// lcmgcd_dp
// Datapath of the lcm/gcd unit: binary gcd registers, restoring divider,
// shift-add multiplier and the result register.
// ----------------------------------------------------------------------------
module lcmgcd_dp #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                i_clk,
    input  lcmgcd_pkg::t_lg_in  i_in_data,
    input  lcmgcd_pkg::t_lg_cmd i_cmd,
    output lcmgcd_pkg::t_lg_sts o_sts,
    output lcmgcd_pkg::t_lg_out o_out_data
);
    import lcmgcd_pkg::*;

    localparam int W    = OPERAND_WIDTH;
    localparam int CntW = $clog2(OPERAND_WIDTH + 1);

    // gcd working values and common power of two
    logic [W-1:0]     r_x, n_x;
    logic [W-1:0]     r_y, n_y;
    logic [CntW-1:0]  r_k, n_k;
    logic [W-1:0]     r_g, n_g;
    // divider
    logic [W-1:0]     r_rem, n_rem;
    logic [W-1:0]     r_quo, n_quo;
    // multiplier
    logic [LCM_W-1:0] r_acc, n_acc;
    logic [LCM_W-1:0] r_mcand, n_mcand;
    // step counter for divide and multiply
    logic [CntW-1:0]  r_cnt, n_cnt;
    t_lg_out          r_res, n_res;

    logic [W-1:0] w_a;
    logic [W-1:0] w_b;
    logic         w_zero;
    logic         w_x_gt;
    logic [W-1:0] w_diff;
    logic [W:0]   w_rem_sh;
    logic [W:0]   w_rem_sub;
    logic         w_ge;
    logic         w_cnt_last;

    // operands cut to the configured width
    assign w_a = W'(i_in_data.operand_a);
    assign w_b = W'(i_in_data.operand_b);

    // status
    assign w_zero     = (r_x == '0) || (r_y == '0);
    assign w_cnt_last = (r_cnt == CntW'(W - 1));
    assign o_sts.zero_op   = w_zero;
    assign o_sts.both_even = !r_x[0] && !r_y[0];
    assign o_sts.equal     = (r_x == r_y);
    assign o_sts.cnt_last  = w_cnt_last;

    // shared compare and subtract for the gcd step
    assign w_x_gt = (r_x > r_y);
    assign w_diff = w_x_gt ? (r_x - r_y) : (r_y - r_x);

    // restoring divider step
    assign w_rem_sh  = {r_rem, r_quo[W-1]};
    assign w_ge      = (w_rem_sh >= {1'b0, r_g});
    assign w_rem_sub = w_rem_sh - {1'b0, r_g};

    // next values
    always_comb begin
        n_x     = r_x;
        n_y     = r_y;
        n_k     = r_k;
        n_g     = r_g;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_acc   = r_acc;
        n_mcand = r_mcand;
        n_cnt   = r_cnt;
        n_res   = r_res;

        if (i_cmd.load) begin
            n_x     = w_a;
            n_y     = w_b;
            n_k     = '0;
            n_rem   = '0;
            n_quo   = w_a;
            n_acc   = '0;
            n_mcand = LCM_W'(w_b);
            n_cnt   = '0;
        end

        if (i_cmd.twos) begin
            n_x = r_x >> 1;
            n_y = r_y >> 1;
            n_k = r_k + 1'b1;
        end

        // binary gcd: halve an even value, else halve the difference
        if (i_cmd.gcd_step) begin
            priority if (!r_x[0]) begin
                n_x = r_x >> 1;
            end else if (!r_y[0]) begin
                n_y = r_y >> 1;
            end else if (w_x_gt) begin
                n_x = w_diff >> 1;
            end else begin
                n_y = w_diff >> 1;
            end
        end

        if (i_cmd.gcd_done) begin
            n_g = r_x << r_k;
        end

        if (i_cmd.div_step) begin
            n_rem = w_ge ? w_rem_sub[W-1:0] : w_rem_sh[W-1:0];
            n_quo = {r_quo[W-2:0], w_ge};
        end

        // quotient times b, low bits first
        if (i_cmd.mul_step) begin
            if (r_quo[0]) begin
                n_acc = r_acc + r_mcand;
            end
            n_mcand = r_mcand << 1;
            n_quo   = r_quo >> 1;
        end

        if (i_cmd.div_step || i_cmd.mul_step) begin
            n_cnt = w_cnt_last ? '0 : r_cnt + 1'b1;
        end

        if (i_cmd.finish) begin
            n_res.lcm_value = w_zero ? '0 : r_acc;
            n_res.gcd_value = w_zero ? '0 : GCD_W'(r_g);
            n_res.invalid   = w_zero;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_x     <= n_x;
        r_y     <= n_y;
        r_k     <= n_k;
        r_g     <= n_g;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_acc   <= n_acc;
        r_mcand <= n_mcand;
        r_cnt   <= n_cnt;
        r_res   <= n_res;
    end

    assign o_out_data = r_res;

endmodule

### rtl/lcmgcd_chk.sv
// ----------------------------------------------------------------------------
// lcmgcd_chk
// Port-level checks for the lcm/gcd unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "lcm_gcd_unit_macros.svh"

module lcmgcd_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input lcmgcd_pkg::t_lg_in  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input lcmgcd_pkg::t_lg_out o_out_data
);
    import lcmgcd_pkg::*;

    // a taken request keeps the unit busy on the next cycle
    `LG_ASSERT(a_busy_after_req, (i_in_valid && !o_in_stall) |=> o_in_stall, "not busy after request")

    // stalled result holds
    `LG_ASSERT(a_out_hold, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)), "stalled result changed")

    // invalid results carry zero values
    `LG_ASSERT(a_invalid_zero, (o_out_valid && o_out_data.invalid) |-> ((o_out_data.lcm_value == '0) && (o_out_data.gcd_value == '0)), "invalid result not zero")

    // valid results carry nonzero values
    `LG_ASSERT(a_valid_nonzero, (o_out_valid && !o_out_data.invalid) |-> ((o_out_data.lcm_value != '0) && (o_out_data.gcd_value != '0)), "zero value on valid result")

    // reset empties the output
    `LG_ASSERT_RST(a_reset_empty, !i_rst_n |=> !o_out_valid, "output valid after reset")

endmodule

bind lcm_gcd_unit lcmgcd_chk u_lcmgcd_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

### tb/tb_lcm_gcd_unit.sv
// ----------------------------------------------------------------------------
// tb_lcm_gcd_unit
// Self-checking bench for the lcm/gcd unit. A directed set of edge operands
// is followed by a random mix of arbitrary, small, shared-factor, power-of-two,
// divisor and zero operand pairs. Every accepted request is run through a
// local predictor (Euclid, then (a / gcd) * b), and each result is checked
// field by field against the oldest prediction. Both handshake sides insert
// random gaps, and the receiver holds off for long stretches to back up the
// request side.
// ----------------------------------------------------------------------------
module tb_lcm_gcd_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import lcmgcd_pkg::*;

    localparam int OPND_BITS   = 16;
    localparam int RANDOM_REQS = 1430;
    localparam int IDLE_LIMIT  = 4000;
    localparam int DRAIN_WAIT  = 100;
    localparam int PRESS_HOLD  = 600;

    logic    i_clk;
    logic    i_rst_n;
    logic    in_valid;
    logic    in_stall;
    t_lg_in  in_data;
    logic    out_valid;
    logic    out_stall;
    t_lg_out out_data;

    // bench state
    t_lg_in  pending_reqs[$];
    t_lg_out expected_results[$];
    t_lg_out want;
    logic    in_taken;
    int      send_gap;
    int      hold_left;
    bit      send_calm;
    bit      recv_calm;
    int      press_stage;
    int      results_seen;
    int      idle_cycles;
    int      error_count;

    lcm_gcd_unit #(
        .OPERAND_WIDTH(OPND_BITS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    // clock
    always #1 i_clk = ~i_clk;

    // expected lcm and gcd of one request
    function automatic t_lg_out lcm_gcd_of(t_lg_in req);
        logic [63:0] mask;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] rem;
        logic [63:0] a_val;
        logic [63:0] prod;
        t_lg_out     res;
        mask  = (64'd1 << OPND_BITS) - 64'd1;
        a_val = 64'(req.operand_a) & mask;
        x     = a_val;
        y     = 64'(req.operand_b) & mask;
        res   = '0;
        if (x == 64'd0 || y == 64'd0) begin
            res.invalid = 1'b1;
            return res;
        end
        prod = y;
        while (y != 64'd0) begin
            rem = x % y;
            x   = y;
            y   = rem;
        end
        prod          = (a_val / x) * prod;
        res.lcm_value = prod[LCM_W-1:0];
        res.gcd_value = x[GCD_W-1:0];
        return res;
    endfunction

    // gap length: mostly short, a few long, none in calm stretches
    function automatic int pick_gap(bit calm);
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 20);
        else
            return $urandom_range(30, 150);
    endfunction

    // one random operand pair drawn from a mix of shapes
    function automatic t_lg_in make_random_req();
        t_lg_in      req;
        int unsigned kind;
        int unsigned g;
        logic [15:0] tmp;
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            req.operand_a = 16'($urandom);
            req.operand_b = 16'($urandom);
        end else if (kind < 55) begin
            // shared factor
            g = $urandom_range(2, 300);
            req.operand_a = 16'(g * $urandom_range(1, 65535 / g));
            req.operand_b = 16'(g * $urandom_range(1, 65535 / g));
        end else if (kind < 70) begin
            req.operand_a = 16'($urandom_range(1, 40));
            req.operand_b = 16'($urandom_range(1, 40));
        end else if (kind < 82) begin
            // odd values shifted by powers of two
            req.operand_a = 16'(($urandom | 1) << $urandom_range(0, 15));
            req.operand_b = 16'(($urandom | 1) << $urandom_range(0, 15));
        end else if (kind < 92) begin
            // one operand divides the other
            g = $urandom_range(1, 255);
            req.operand_a = 16'(g);
            req.operand_b = 16'(g * $urandom_range(1, 65535 / g));
            if ($urandom_range(0, 1) == 1) begin
                tmp           = req.operand_a;
                req.operand_a = req.operand_b;
                req.operand_b = tmp;
            end
        end else begin
            // zero operand
            req.operand_a = 16'($urandom);
            req.operand_b = 16'($urandom);
            case ($urandom_range(0, 2))
                0: req.operand_a = '0;
                1: req.operand_b = '0;
                default: begin
                    req.operand_a = '0;
                    req.operand_b = '0;
                end
            endcase
        end
        return req;
    endfunction

    task automatic add_req(input logic [15:0] a, input logic [15:0] b);
        t_lg_in req;
        req.operand_a = a;
        req.operand_b = b;
        pending_reqs.push_back(req);
    endtask

    // request driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!in_valid || in_taken) begin
                if ($urandom_range(0, 99) == 0)
                    send_calm = !send_calm;
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    in_data  <= pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    send_gap <= pick_gap(send_calm);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result receiver with random stalls and long hold-offs
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else if ((press_stage == 0 && results_seen >= 150) ||
                     (press_stage == 1 && results_seen >= 800)) begin
            press_stage <= press_stage + 1;
            hold_left   <= PRESS_HOLD - 1;
            out_stall   <= 1'b1;
        end else begin
            if ($urandom_range(0, 99) == 0)
                recv_calm = !recv_calm;
            if (!recv_calm && $urandom_range(0, 99) >= 60) begin
                hold_left <= pick_gap(1'b0);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // prediction on accepted requests, checking of accepted results, watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken    <= 1'b0;
            idle_cycles <= 0;
        end else begin
            in_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
                expected_results.push_back(lcm_gcd_of(in_data));
            if (out_valid && !out_stall) begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0) begin
                    $error("result with no request pending: lcm %0d gcd %0d invalid %0d",
                           out_data.lcm_value, out_data.gcd_value, out_data.invalid);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (out_data.lcm_value !== want.lcm_value) begin
                        $error("lcm_value: expected %0d, got %0d",
                               want.lcm_value, out_data.lcm_value);
                        error_count++;
                    end
                    if (out_data.gcd_value !== want.gcd_value) begin
                        $error("gcd_value: expected %0d, got %0d",
                               want.gcd_value, out_data.gcd_value);
                        error_count++;
                    end
                    if (out_data.invalid !== want.invalid) begin
                        $error("invalid: expected %0d, got %0d",
                               want.invalid, out_data.invalid);
                        error_count++;
                    end
                end
            end
            // watchdog on cycles with no handshake on either side
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        out_stall    = 1'b0;
        in_taken     = 1'b0;
        send_gap     = 0;
        hold_left    = 0;
        send_calm    = 1'b0;
        recv_calm    = 1'b0;
        press_stage  = 0;
        results_seen = 0;
        idle_cycles  = 0;
        error_count  = 0;

        // zero operands
        add_req(16'h0000, 16'h0000);
        add_req(16'h0000, 16'h1234);
        add_req(16'h4321, 16'h0000);
        add_req(16'h0000, 16'hFFFF);
        add_req(16'hFFFF, 16'h0000);
        // operand extremes
        add_req(16'h0001, 16'h0001);
        add_req(16'hFFFF, 16'hFFFF);
        add_req(16'hFFFF, 16'hFFFE);
        add_req(16'hFFFE, 16'hFFFF);
        add_req(16'h0001, 16'hFFFF);
        add_req(16'hFFFF, 16'h0001);
        add_req(16'h8000, 16'h8000);
        add_req(16'h8000, 16'h0001);
        add_req(16'h8000, 16'hFFFF);
        // large primes, then assorted shared factors
        add_req(16'd65521, 16'd65519);
        add_req(16'd12, 16'd18);
        add_req(16'd7, 16'd7);
        add_req(16'd2, 16'd3);
        add_req(16'hAAAA, 16'h5555);
        add_req(16'h5555, 16'hAAAA);
        add_req(16'd4096, 16'd6144);
        add_req(16'd65535, 16'd255);
        add_req(16'd48, 16'd180);
        add_req(16'd32768, 16'd49152);
        repeat (RANDOM_REQS)
            pending_reqs.push_back(make_random_req());

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // all requests accepted, then all results back, then a quiet tail
        @(posedge i_clk);
        while (pending_reqs.size() != 0 || in_valid)
            @(posedge i_clk);
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (expected_results.size() != 0) begin
            $error("%0d results never arrived", expected_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
